>>> hdl/huffman_code_builder_macros.svh
// assertion helpers used by the checker file
`ifndef HUFFMAN_CODE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define HCB_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HCB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hcb_pkg.sv
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF  = 64;
    localparam int MAX_CODE_LEN_DEF = 63;

    localparam int SYM_W      = 8;
    localparam int FREQ_W     = 32;
    localparam int LEN_W      = 6;
    localparam int CODE_OUT_W = 63;
    localparam int DEPTH_W    = 7;
    localparam int CODE_W     = 64;

    // one queued input item, already classified by the front
    typedef struct packed {
        logic [SYM_W-1:0]  symbol;
        logic [FREQ_W-1:0] frequency;
        logic              store;
        logic              build;
    } hcb_item_t;

endpackage

>>> hdl/hcb_sym_if.sv
interface hcb_sym_if;
    import hcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [SYM_W-1:0]  symbol;
    logic [FREQ_W-1:0] frequency;
    logic              last_symbol;

    modport source (output valid, output symbol, output frequency, output last_symbol,
                    input ready);
    modport sink   (input valid, input symbol, input frequency, input last_symbol,
                    output ready);
endinterface

>>> hdl/hcb_code_if.sv
interface hcb_code_if;
    import hcb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SYM_W-1:0]      leaf_symbol;
    logic [LEN_W-1:0]      code_length;
    logic [CODE_OUT_W-1:0] code_bits;
    logic                  last_code;

    modport source (output valid, output leaf_symbol, output code_length, output code_bits,
                    output last_code, input ready);
    modport sink   (input valid, input leaf_symbol, input code_length, input code_bits,
                    input last_code, output ready);
endinterface

>>> hdl/huffman_code_builder.sv
// channel   dir  payload                                          moves
// symbols   in   symbol, frequency, last_symbol                   one (symbol, count) pair
// codes     out  leaf_symbol, code_length, code_bits, last_code   one leaf code
//
// loading: one pair a cycle into a two-entry queue while it has room; the back end retires one a cycle while idle
// build: after the last pair, each heap level of a sift reads both children, then compares and writes
// emission: the tree walk visits each node in S_WALK, then S_DESCEND or S_LEAF, and pops the stack in S_POP
// reset clears all control; heap, child, leaf and stack memories are never cleared
// a stalled codes sink holds the walk; the queue keeps taking pairs until it fills
module huffman_code_builder #(
    parameter int MAX_SYMBOLS  = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    hcb_sym_if.sink    symbols,
    hcb_code_if.source codes
);
    import hcb_pkg::*;

    // front to queue
    logic      push_valid;
    hcb_item_t push_item;
    logic      push_ready;

    // queue to back end
    logic      pop_valid;
    hcb_item_t pop_item;
    logic      pop;

    // front counts pairs, tags each as stored or dropped, and flags the build trigger
    hcb_front #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .symbols    (symbols),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    // short queue so the front keeps taking transfers while the back is busy
    hcb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop        (pop)
    );

    // back end: stores leaves, runs the heap build and merges, walks the tree
    hcb_back #(
        .MAX_SYMBOLS  (MAX_SYMBOLS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (pop_valid),
        .q_item  (pop_item),
        .q_pop   (pop),
        .codes   (codes)
    );

endmodule

>>> hdl/hcb_front.sv
module hcb_front #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    hcb_sym_if.sink           symbols,
    output logic              push_valid,
    output hcb_pkg::hcb_item_t push_item,
    input  logic              push_ready
);
    import hcb_pkg::*;

    localparam int CNT_W = $clog2(MAX_SYMBOLS + 1);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             take;

    assign symbols.ready = push_ready;
    assign take          = symbols.valid && push_ready;
    assign push_valid    = symbols.valid;

    // pairs past the table size are dropped; a flagged one still builds
    always_comb
    begin
        push_item.symbol    = symbols.symbol;
        push_item.frequency = symbols.frequency;
        push_item.store     = (cnt_reg < CNT_W'(MAX_SYMBOLS));
        push_item.build     = symbols.last_symbol;
        cnt_next            = cnt_reg;
        if (take)
        begin
            if (symbols.last_symbol)
            begin
                cnt_next = '0;
            end
            else if (push_item.store)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/hcb_queue.sv
module hcb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  hcb_pkg::hcb_item_t push_item,
    output logic               push_ready,
    output logic               pop_valid,
    output hcb_pkg::hcb_item_t pop_item,
    input  logic               pop
);
    import hcb_pkg::*;

    hcb_item_t  slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

>>> hdl/hcb_back.sv
module hcb_back #(
    parameter int MAX_SYMBOLS  = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  hcb_pkg::hcb_item_t q_item,
    output logic               q_pop,
    hcb_code_if.source         codes
);
    import hcb_pkg::*;

    localparam int IDX_W  = $clog2(MAX_SYMBOLS);
    localparam int CNT_W  = $clog2(MAX_SYMBOLS + 1);
    localparam int NODE_W = $clog2(2 * MAX_SYMBOLS);
    localparam int W_W    = FREQ_W + IDX_W;
    localparam int POS_W  = IDX_W + 2;

    typedef struct packed {
        logic [W_W-1:0]    w;
        logic [NODE_W-1:0] n;
    } entry_t;

    typedef struct packed {
        logic [NODE_W-1:0]  n;
        logic [DEPTH_W-1:0] d;
        logic [CODE_W-1:0]  c;
    } frame_t;

    typedef enum logic [15:0] {
        S_IDLE     = 16'b0000_0000_0000_0001,
        S_INIT_RD  = 16'b0000_0000_0000_0010,
        S_INIT_LD  = 16'b0000_0000_0000_0100,
        S_SIFT_RD  = 16'b0000_0000_0000_1000,
        S_SIFT_CMP = 16'b0000_0000_0001_0000,
        S_TAKE_RD  = 16'b0000_0000_0010_0000,
        S_TAKE_LD  = 16'b0000_0000_0100_0000,
        S_MERGE    = 16'b0000_0000_1000_0000,
        S_PUT_RD   = 16'b0000_0001_0000_0000,
        S_PUT_CMP  = 16'b0000_0010_0000_0000,
        S_ROOT     = 16'b0000_0100_0000_0000,
        S_ROOT_LD  = 16'b0000_1000_0000_0000,
        S_WALK     = 16'b0001_0000_0000_0000,
        S_DESCEND  = 16'b0010_0000_0000_0000,
        S_LEAF     = 16'b0100_0000_0000_0000,
        S_POP      = 16'b1000_0000_0000_0000
    } state_t;

    // storage
    entry_t              heap_mem  [MAX_SYMBOLS];
    logic [SYM_W-1:0]    leaf_mem  [MAX_SYMBOLS];
    logic [2*NODE_W-1:0] kid_mem   [MAX_SYMBOLS];
    frame_t              stack_mem [MAX_SYMBOLS];

    logic                heap_we;
    logic [IDX_W-1:0]    heap_waddr;
    entry_t              heap_wdata;
    logic [IDX_W-1:0]    heap_ra0;
    logic [IDX_W-1:0]    heap_ra1;
    entry_t              heap_rd0;
    entry_t              heap_rd1;
    logic                leaf_we;
    logic [SYM_W-1:0]    leaf_q;
    logic                kid_we;
    logic [IDX_W-1:0]    kid_waddr;
    logic [2*NODE_W-1:0] kid_wdata;
    logic [2*NODE_W-1:0] kid_q;
    logic                stack_we;
    frame_t              stack_wdata;
    frame_t              stack_q;

    // control and working registers
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [NODE_W-1:0]  nodes_reg, nodes_next;
    logic [CNT_W-1:0]   size_reg, size_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   start_reg, start_next;
    logic               init_mode_reg, init_mode_next;
    logic               second_reg, second_next;
    logic [CNT_W-1:0]   sp_reg, sp_next;
    logic               out_valid_reg, out_valid_next;
    entry_t             cur_reg, cur_next;
    entry_t             a_reg, a_next;
    entry_t             b_reg, b_next;
    logic [NODE_W-1:0]  node_reg, node_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [SYM_W-1:0]      out_sym_reg;
    logic [LEN_W-1:0]      out_len_reg;
    logic [CODE_OUT_W-1:0] out_code_reg;
    logic                  out_last_reg;
    logic                  out_load;

    logic [POS_W-1:0]   l_pos;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   size_pos;
    logic               l_win;
    logic               r_win;
    logic [W_W-1:0]     best_w;
    logic [IDX_W-1:0]   parent;
    logic [CNT_W-1:0]   leaves;
    logic               deep_ok;
    logic [DEPTH_W-1:0] depth_adv;
    logic [CODE_W-1:0]  code_l;
    logic [CODE_W-1:0]  code_r;

    assign l_pos    = POS_W'({idx_reg, 1'b1});
    assign r_pos    = l_pos + POS_W'(1);
    assign size_pos = POS_W'(size_reg);
    assign l_win    = (l_pos < size_pos) && (heap_rd0.w < cur_reg.w);
    assign best_w   = l_win ? heap_rd0.w : cur_reg.w;
    assign r_win    = (r_pos < size_pos) && (heap_rd1.w < best_w);
    assign parent   = (idx_reg - IDX_W'(1)) >> 1;
    assign leaves   = q_item.store ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    // saturating descent
    assign deep_ok   = (depth_reg < DEPTH_W'(MAX_CODE_LEN));
    assign depth_adv = deep_ok ? (depth_reg + DEPTH_W'(1)) : depth_reg;
    assign code_l    = deep_ok ? {code_reg[CODE_W-2:0], 1'b0} : code_reg;
    assign code_r    = deep_ok ? {code_reg[CODE_W-2:0], 1'b1} : code_reg;

    assign q_pop = (state_reg == S_IDLE);

    assign codes.valid       = out_valid_reg;
    assign codes.leaf_symbol = out_sym_reg;
    assign codes.code_length = out_len_reg;
    assign codes.code_bits   = out_code_reg;
    assign codes.last_code   = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rd0 <= heap_mem[heap_ra0];
        heap_rd1 <= heap_mem[heap_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (leaf_we)
        begin
            leaf_mem[cnt_reg[IDX_W-1:0]] <= q_item.symbol;
        end
        leaf_q <= leaf_mem[node_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (kid_we)
        begin
            kid_mem[kid_waddr] <= kid_wdata;
        end
        kid_q <= kid_mem[IDX_W'(node_reg - NODE_W'(cnt_reg))];
    end

    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[sp_reg[IDX_W-1:0]] <= stack_wdata;
        end
        stack_q <= stack_mem[IDX_W'(sp_reg - CNT_W'(1))];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        nodes_next     = nodes_reg;
        size_next      = size_reg;
        idx_next       = idx_reg;
        start_next     = start_reg;
        init_mode_next = init_mode_reg;
        second_next    = second_reg;
        sp_next        = sp_reg;
        cur_next       = cur_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        node_next      = node_reg;
        depth_next     = depth_reg;
        code_next      = code_reg;
        out_load       = 1'b0;
        heap_we        = 1'b0;
        heap_waddr     = idx_reg;
        heap_wdata     = cur_reg;
        heap_ra0       = idx_reg;
        heap_ra1       = idx_reg;
        leaf_we        = 1'b0;
        kid_we         = 1'b0;
        kid_waddr      = IDX_W'(nodes_reg - NODE_W'(cnt_reg));
        kid_wdata      = {a_reg.n, b_reg.n};
        stack_we       = 1'b0;
        stack_wdata    = '{n: kid_q[NODE_W-1:0], d: depth_adv, c: code_r};

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_item.store)
                    begin
                        heap_we    = 1'b1;
                        heap_waddr = cnt_reg[IDX_W-1:0];
                        heap_wdata = '{w: W_W'(q_item.frequency), n: NODE_W'(cnt_reg)};
                        leaf_we    = 1'b1;
                        cnt_next   = cnt_reg + CNT_W'(1);
                    end
                    if (q_item.build)
                    begin
                        size_next      = leaves;
                        nodes_next     = NODE_W'(leaves);
                        idx_next       = IDX_W'((leaves - CNT_W'(1)) >> 1);
                        start_next     = IDX_W'((leaves - CNT_W'(1)) >> 1);
                        init_mode_next = 1'b1;
                        state_next     = S_INIT_RD;
                    end
                end
            end
            S_INIT_RD:
            begin
                heap_ra0   = idx_reg;
                state_next = S_INIT_LD;
            end
            S_INIT_LD:
            begin
                cur_next   = heap_rd0;
                state_next = S_SIFT_RD;
            end
            S_SIFT_RD:
            begin
                heap_ra0   = l_pos[IDX_W-1:0];
                heap_ra1   = r_pos[IDX_W-1:0];
                state_next = S_SIFT_CMP;
            end
            S_SIFT_CMP:
            begin
                heap_we = 1'b1;
                if (r_win)
                begin
                    heap_wdata = heap_rd1;
                    idx_next   = r_pos[IDX_W-1:0];
                    state_next = S_SIFT_RD;
                end
                else if (l_win)
                begin
                    heap_wdata = heap_rd0;
                    idx_next   = l_pos[IDX_W-1:0];
                    state_next = S_SIFT_RD;
                end
                else if (init_mode_reg)
                begin
                    // the next bottom-up sift starts one index lower than the last start
                    heap_wdata = cur_reg;
                    if (start_reg == '0)
                    begin
                        init_mode_next = 1'b0;
                        second_next    = 1'b0;
                        state_next     = (size_reg == CNT_W'(1)) ? S_ROOT : S_TAKE_RD;
                    end
                    else
                    begin
                        start_next = start_reg - IDX_W'(1);
                        idx_next   = start_reg - IDX_W'(1);
                        state_next = S_INIT_RD;
                    end
                end
                else
                begin
                    // extraction shrinks the heap only after the sift
                    heap_wdata  = cur_reg;
                    size_next   = size_reg - CNT_W'(1);
                    second_next = 1'b1;
                    state_next  = second_reg ? S_MERGE : S_TAKE_RD;
                end
            end
            S_TAKE_RD:
            begin
                heap_ra0   = '0;
                heap_ra1   = IDX_W'(size_reg - CNT_W'(1));
                state_next = S_TAKE_LD;
            end
            S_TAKE_LD:
            begin
                if (second_reg)
                begin
                    b_next = heap_rd0;
                end
                else
                begin
                    a_next = heap_rd0;
                end
                cur_next   = heap_rd1;
                idx_next   = '0;
                state_next = S_SIFT_RD;
            end
            S_MERGE:
            begin
                kid_we     = 1'b1;
                cur_next   = '{w: a_reg.w + b_reg.w, n: nodes_reg};
                nodes_next = nodes_reg + NODE_W'(1);
                idx_next   = size_reg[IDX_W-1:0];
                size_next  = size_reg + CNT_W'(1);
                state_next = S_PUT_RD;
            end
            S_PUT_RD:
            begin
                heap_ra0 = parent;
                if (idx_reg == '0)
                begin
                    heap_we     = 1'b1;
                    heap_wdata  = cur_reg;
                    second_next = 1'b0;
                    state_next  = (size_reg == CNT_W'(1)) ? S_ROOT : S_TAKE_RD;
                end
                else
                begin
                    state_next = S_PUT_CMP;
                end
            end
            S_PUT_CMP:
            begin
                heap_we = 1'b1;
                if (cur_reg.w < heap_rd0.w)
                begin
                    heap_wdata = heap_rd0;
                    idx_next   = parent;
                    state_next = S_PUT_RD;
                end
                else
                begin
                    heap_wdata  = cur_reg;
                    second_next = 1'b0;
                    state_next  = (size_reg == CNT_W'(1)) ? S_ROOT : S_TAKE_RD;
                end
            end
            S_ROOT:
            begin
                heap_ra0   = '0;
                state_next = S_ROOT_LD;
            end
            S_ROOT_LD:
            begin
                node_next  = heap_rd0.n;
                depth_next = '0;
                code_next  = '0;
                sp_next    = '0;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                state_next = (node_reg < NODE_W'(cnt_reg)) ? S_LEAF : S_DESCEND;
            end
            S_DESCEND:
            begin
                stack_we   = 1'b1;
                sp_next    = sp_reg + CNT_W'(1);
                node_next  = kid_q[2*NODE_W-1:NODE_W];
                depth_next = depth_adv;
                code_next  = code_l;
                state_next = S_WALK;
            end
            S_LEAF:
            begin
                if (!out_valid_reg || codes.ready)
                begin
                    out_load = 1'b1;
                    if (sp_reg == '0)
                    begin
                        cnt_next   = '0;
                        nodes_next = '0;
                        size_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        sp_next    = sp_reg - CNT_W'(1);
                        state_next = S_POP;
                    end
                end
            end
            S_POP:
            begin
                node_next  = stack_q.n;
                depth_next = stack_q.d;
                code_next  = stack_q.c;
                state_next = S_WALK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        node_reg  <= node_next;
        depth_reg <= depth_next;
        code_reg  <= code_next;
        if (out_load)
        begin
            out_sym_reg  <= leaf_q;
            out_len_reg  <= depth_reg[LEN_W-1:0];
            out_code_reg <= code_reg[CODE_OUT_W-1:0];
            out_last_reg <= (sp_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            nodes_reg     <= '0;
            size_reg      <= '0;
            idx_reg       <= '0;
            start_reg     <= '0;
            init_mode_reg <= 1'b0;
            second_reg    <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            nodes_reg     <= nodes_next;
            size_reg      <= size_next;
            idx_reg       <= idx_next;
            start_reg     <= start_next;
            init_mode_reg <= init_mode_next;
            second_reg    <= second_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> hdl/hcb_checker.sv
`include "huffman_code_builder_macros.svh"

module hcb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        codes_valid,
    input logic        codes_ready,
    input logic [7:0]  codes_leaf_symbol,
    input logic [5:0]  codes_code_length,
    input logic [62:0] codes_code_bits,
    input logic        codes_last_code
);

    // a stalled code transfer keeps its symbol, code bits and last flag
    `HCB_ASSERT_NEXT(a_hold, codes_valid && !codes_ready, codes_valid && $stable(codes_leaf_symbol) && $stable(codes_code_bits) && $stable(codes_last_code), "code payload changed while stalled")

    // no code bit above the code length
    `HCB_ASSERT(a_bits, codes_valid, (codes_code_bits >> codes_code_length) == 63'd0, "code bits exceed length")

    // a zero-length code only comes from a single-symbol set
    `HCB_ASSERT(a_single, codes_valid && codes_code_length == 6'd0, codes_last_code, "zero length code not last")

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .codes_valid       (codes.valid),
    .codes_ready       (codes.ready),
    .codes_leaf_symbol (codes.leaf_symbol),
    .codes_code_length (codes.code_length),
    .codes_code_bits   (codes.code_bits),
    .codes_last_code   (codes.last_code)
);
